// File: sv/mtf_pkg.sv
package mtf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WINDOW_DEFAULT = 5;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type roll_sample;
      sample_type pitch_sample;
   } req_type;

   typedef struct packed {
      sample_type first_angle;
      sample_type second_angle;
   } rsp_type;

endpackage

// File: sv/mtf_lane.sv
module mtf_lane #(
   parameter int WINDOW = mtf_pkg::WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mtf_pkg::sample_type sample,
   output mtf_pkg::sample_type median
);

   localparam int HIST_DEPTH = WINDOW - 1;
   localparam int RANK_BITS = $clog2(WINDOW);
   localparam logic [RANK_BITS-1:0] MID_RANK = RANK_BITS'(WINDOW / 2);

   mtf_pkg::sample_type hist_ff [HIST_DEPTH];
   mtf_pkg::sample_type hist_in [HIST_DEPTH];
   mtf_pkg::sample_type elem [WINDOW];
   mtf_pkg::sample_type median_ff;
   mtf_pkg::sample_type median_in;

   // Each element's rank counts smaller values, and equal values at lower
   // positions, so the ranks form a permutation and exactly one is the middle.
   always_comb begin
      logic [WINDOW-1:0] below;
      logic [RANK_BITS-1:0] rank;
      elem[0] = sample;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         elem[i + 1] = hist_ff[i];
      end
      median_in = '0;
      for (int i = 0; i < WINDOW; i++) begin
         for (int j = 0; j < WINDOW; j++) begin
            below[j] = (elem[j] < elem[i]) || ((j < i) && (elem[j] == elem[i]));
         end
         rank = RANK_BITS'($countones(below));
         if (rank == MID_RANK) begin
            median_in = median_in | elem[i];
         end
      end
   end

   always_comb begin
      hist_in[0] = sample;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (load) begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         median_ff <= median_in;
      end
   end

   assign median = median_ff;

endmodule

// File: sv/mtf_merge.sv
module mtf_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  mtf_pkg::sample_type pitch_median,
   input  mtf_pkg::sample_type roll_median,
   output logic                in_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mtf_pkg::rsp_type    rsp_data
);

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   mtf_pkg::rsp_type rsp_data_ff;
   mtf_pkg::rsp_type rsp_data_in;

   assign in_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in.first_angle = pitch_median;
      if (roll_median == mtf_pkg::SAMPLE_MIN) begin
         rsp_data_in.second_angle = mtf_pkg::SAMPLE_MAX;
      end else begin
         rsp_data_in.second_angle = -roll_median;
      end
      rsp_valid_in = in_ready ? in_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_no_min_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.second_angle != mtf_pkg::SAMPLE_MIN))
      else $error("negated roll median left at the most negative value");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (rsp_valid_ff && rsp_stall))
      else $error("merge stage blocked without a waiting result");

endmodule

// File: sv/median5_tilt_filter.sv
// Each axis lane registers its median of an accepted request, then the merge stage
// registers the result on rsp_valid. Throughput: one request per cycle while rsp_stall
// is low; lanes settle medians in comparator rank networks; merge holds one result.
// Reset clears both sample histories to zero and empties the pipeline.
module median5_tilt_filter #(
   parameter int WINDOW = mtf_pkg::WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtf_pkg::rsp_type rsp_data
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_ready;
   logic                merge_ready;
   logic                req_accept;
   mtf_pkg::sample_type roll_median;
   mtf_pkg::sample_type pitch_median;

   assign s1_ready = !s1_valid_ff || merge_ready;
   assign req_stall = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   mtf_lane #(.WINDOW(WINDOW)) u_roll_lane (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept),
      .sample (req_data.roll_sample),
      .median (roll_median)
   );

   mtf_lane #(.WINDOW(WINDOW)) u_pitch_lane (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept),
      .sample (req_data.pitch_sample),
      .median (pitch_median)
   );

   mtf_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .pitch_median (pitch_median),
      .roll_median  (roll_median),
      .in_ready     (merge_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

// File: dv/tb_median5_tilt_filter.sv
`timescale 1ns / 100ps

module tb_median5_tilt_filter;

   localparam int CYCLE_LIMIT = 200000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mtf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mtf_pkg::rsp_type rsp_data;

   mtf_pkg::sample_type roll_history [4];
   mtf_pkg::sample_type pitch_history [4];
   mtf_pkg::sample_type roll_walk = '0;
   mtf_pkg::sample_type pitch_walk = '0;
   mtf_pkg::rsp_type    expected_angles [$];

   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int cycle_count = 0;
   int error_count = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int saturation_count = 0;

   median5_tilt_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_angles.size());
         $display("tb_median5_tilt_filter: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= rsp_stalls_on && ($urandom_range(0, 99) < 31);
   end

   task automatic report_mismatch(input string what, input mtf_pkg::sample_type got_value,
                                  input mtf_pkg::sample_type want_value);
      $display("Mismatch at cycle %0d in %s: got %0d, expected %0d.",
               cycle_count, what, got_value, want_value);
      error_count++;
   endtask

   function automatic mtf_pkg::sample_type median_of_five(
      input mtf_pkg::sample_type a, b, c, d, e);
      mtf_pkg::sample_type vals [5];
      mtf_pkg::sample_type key;
      int j;
      vals[0] = a;
      vals[1] = b;
      vals[2] = c;
      vals[3] = d;
      vals[4] = e;
      for (int i = 1; i < 5; i++) begin
         key = vals[i];
         j = i - 1;
         while (j >= 0 && vals[j] > key) begin
            vals[j + 1] = vals[j];
            j--;
         end
         vals[j + 1] = key;
      end
      return vals[2];
   endfunction

   task automatic record_tilt_request(input mtf_pkg::req_type r);
      mtf_pkg::sample_type roll_med;
      mtf_pkg::sample_type pitch_med;
      mtf_pkg::rsp_type    want;
      pitch_med = median_of_five(r.pitch_sample, pitch_history[0], pitch_history[1],
                                 pitch_history[2], pitch_history[3]);
      roll_med = median_of_five(r.roll_sample, roll_history[0], roll_history[1],
                                roll_history[2], roll_history[3]);
      want.first_angle = pitch_med;
      if (roll_med == mtf_pkg::SAMPLE_MIN) begin
         want.second_angle = mtf_pkg::SAMPLE_MAX;
         saturation_count++;
      end else begin
         want.second_angle = mtf_pkg::sample_type'(-roll_med);
      end
      expected_angles.push_back(want);
      for (int i = 3; i > 0; i--) begin
         roll_history[i] = roll_history[i - 1];
         pitch_history[i] = pitch_history[i - 1];
      end
      roll_history[0] = r.roll_sample;
      pitch_history[0] = r.pitch_sample;
   endtask

   always @(posedge clock) begin
      mtf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_angles.size() == 0) begin
            report_mismatch("result with no request waiting", rsp_data.first_angle, '0);
         end else begin
            want = expected_angles.pop_front();
            if (rsp_data.first_angle !== want.first_angle) begin
               report_mismatch("first_angle", rsp_data.first_angle, want.first_angle);
            end
            if (rsp_data.second_angle !== want.second_angle) begin
               report_mismatch("second_angle", rsp_data.second_angle, want.second_angle);
            end
         end
      end
   end

   task automatic send_tilt_request(input mtf_pkg::sample_type roll,
                                    input mtf_pkg::sample_type pitch);
      mtf_pkg::req_type r;
      r.roll_sample = roll;
      r.pitch_sample = pitch;
      while (req_gaps_on && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(posedge clock);
      end while (req_stall);
      requests_sent++;
      record_tilt_request(r);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_angles.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic mtf_pkg::sample_type pick_sample(input mtf_pkg::sample_type around);
      case ($urandom_range(0, 9))
         0, 1, 2: return mtf_pkg::sample_type'($urandom);
         3, 4: begin
            case ($urandom_range(0, 6))
               0: return mtf_pkg::SAMPLE_MIN;
               1: return mtf_pkg::sample_type'(mtf_pkg::SAMPLE_MIN + 1);
               2: return mtf_pkg::sample_type'(-1);
               3: return '0;
               4: return mtf_pkg::sample_type'(1);
               5: return mtf_pkg::sample_type'(mtf_pkg::SAMPLE_MAX - 1);
               default: return mtf_pkg::SAMPLE_MAX;
            endcase
         end
         default: return mtf_pkg::sample_type'(around + $urandom_range(0, 64) - 32);
      endcase
   endfunction

   // The reset zeros of the history must take part in the first medians.
   task automatic test_startup_history();
      send_tilt_request(mtf_pkg::sample_type'(16), mtf_pkg::sample_type'(-16));
      send_tilt_request(mtf_pkg::sample_type'(-32), mtf_pkg::sample_type'(32));
      send_tilt_request(mtf_pkg::sample_type'(48), mtf_pkg::sample_type'(-48));
      send_tilt_request(mtf_pkg::sample_type'(-64), mtf_pkg::sample_type'(64));
      send_tilt_request(mtf_pkg::sample_type'(80), mtf_pkg::sample_type'(-80));
   endtask

   task automatic test_extreme_samples();
      repeat (3) send_tilt_request(mtf_pkg::SAMPLE_MIN, mtf_pkg::SAMPLE_MAX);
      repeat (3) send_tilt_request(mtf_pkg::SAMPLE_MAX, mtf_pkg::SAMPLE_MIN);
      repeat (2) send_tilt_request(mtf_pkg::SAMPLE_MIN, mtf_pkg::SAMPLE_MIN);
      send_tilt_request(mtf_pkg::SAMPLE_MIN, mtf_pkg::SAMPLE_MAX);
      repeat (3) send_tilt_request(mtf_pkg::sample_type'(mtf_pkg::SAMPLE_MIN + 1),
                                   mtf_pkg::sample_type'(-1));
      send_tilt_request(mtf_pkg::sample_type'(1), '0);
      send_tilt_request(mtf_pkg::sample_type'(-1), mtf_pkg::sample_type'(1));
      send_tilt_request(mtf_pkg::sample_type'(mtf_pkg::SAMPLE_MAX - 1),
                        mtf_pkg::sample_type'(mtf_pkg::SAMPLE_MIN + 1));
   endtask

   task automatic test_random_samples(input int count);
      int sent;
      int run;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 39) == 0) begin
            run = $urandom_range(3, 5);
            repeat (run) begin
               pitch_walk = pick_sample(pitch_walk);
               send_tilt_request(mtf_pkg::SAMPLE_MIN, pitch_walk);
               sent++;
            end
         end else begin
            roll_walk = pick_sample(roll_walk);
            pitch_walk = pick_sample(pitch_walk);
            send_tilt_request(roll_walk, pitch_walk);
            sent++;
         end
      end
   endtask

   task automatic test_pause_until_drained();
      test_random_samples(15);
      wait_until_drained();
      test_random_samples(15);
      wait_until_drained();
      test_random_samples(10);
   endtask

   task automatic test_back_to_back(input int count);
      req_gaps_on = 1'b0;
      rsp_stalls_on <= 1'b0;
      test_random_samples(count);
      req_gaps_on = 1'b1;
      rsp_stalls_on <= 1'b1;
   endtask

   task automatic finish_run();
      wait_until_drained();
      repeat (8) @(posedge clock);
      if (expected_angles.size() != 0) begin
         report_mismatch("results never delivered", '0, '0);
      end
      $display("Sent %0d requests and checked %0d results, %0d of them with a saturated",
               requests_sent, results_checked, saturation_count);
      $display("roll median, under random gaps, random stalls, a drain pause and a burst.");
      if (error_count == 0) begin
         $display("tb_median5_tilt_filter: done, clean");
      end else begin
         $display("tb_median5_tilt_filter: done, errors");
      end
      $finish;
   endtask

   initial begin
      for (int i = 0; i < 4; i++) begin
         roll_history[i] = '0;
         pitch_history[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_startup_history();
      test_extreme_samples();
      test_random_samples(200);
      test_pause_until_drained();
      test_back_to_back(150);
      test_random_samples(150);
      finish_run();
   end

endmodule

// File: filelist.f
sv/mtf_pkg.sv
sv/mtf_lane.sv
sv/mtf_merge.sv
sv/median5_tilt_filter.sv
dv/tb_median5_tilt_filter.sv
